// ===== src/zdp_pkg.sv =====
// ----------------------------------------------------------------------------
// zdp_pkg
// Shared widths, register codes and control types of the INT8 zero-point
// dot product unit.
// ----------------------------------------------------------------------------
package zdp_pkg;

    localparam int OPND_W    = 8;   // one int8 operand
    localparam int PROD_W    = 18;  // (a - za) * (b - zb), both in -255..255
    localparam int USED_W    = 3;   // lanes_used field
    localparam int SUM_W     = 32;  // wrapping accumulator
    localparam int SCALED_W  = 64;
    localparam int MULT_W    = 31;
    localparam int SHIFT_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = MULT_W;
    localparam int OUT_TDATA_W = SUM_W + SCALED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_A      = 2'd0,
        CFG_ZERO_B      = 2'd1,
        CFG_SCALE_MULT  = 2'd2,
        CFG_SCALE_SHIFT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_beat_ctl;

endpackage

// ===== src/int8_zero_point_dot_product_unit.sv =====
// ----------------------------------------------------------------------------
// int8_zero_point_dot_product_unit
// One output element of an INT8 quantized matrix product: zero-point
// corrected lane products accumulated over a run, then rescaled.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_axis_tready is high. Each beat carries
// LANES operand pairs that are multiplied in parallel lanes and summed into
// a wrapping 32-bit accumulator; the beat with tlast set emits one result
// through four register stages loaded from the accepting edge on (lane
// multiply, accumulate, 32x32 scale multiply, round and shift). The
// whole pipeline holds only while a result sits in the output register and
// m_axis_tready is low; otherwise s_axis_tready stays high. Configuration is
// written through i_cfg_we / i_cfg_idx / i_cfg_data while no run is in flight.
module int8_zero_point_dot_product_unit
    import zdp_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // input beats
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [a_lane0 .. a_lane(LANES-1), b_lane0 .. b_lane(LANES-1), lanes_used, zero pad]
    input  logic [((2*LANES*OPND_W+USED_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,   // last_in_sum
    // result beats
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [raw_sum (31:0), scaled_value (95:32)]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int USED_LSB = 2 * LANES * OPND_W;

    logic signed [OPND_W-1:0]  r_zero_a;
    logic signed [OPND_W-1:0]  r_zero_b;
    logic [MULT_W-1:0]         r_scale_mult;
    logic [SHIFT_W-1:0]        r_scale_shift;

    logic                      w_en;
    logic [USED_W-1:0]         w_used;
    logic [LANES-1:0]          w_lane_on;
    logic signed [LANES-1:0][PROD_W-1:0] w_prod;
    t_beat_ctl                 r_s1_ctl;
    t_beat_ctl                 n_s1_ctl;
    logic                      w_sum_valid;
    logic signed [SUM_W-1:0]   w_raw;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_a      <= '0;
            r_zero_b      <= '0;
            r_scale_mult  <= MULT_W'(1);
            r_scale_shift <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ZERO_A:      r_zero_a      <= signed'(i_cfg_data[OPND_W-1:0]);
                CFG_ZERO_B:      r_zero_b      <= signed'(i_cfg_data[OPND_W-1:0]);
                CFG_SCALE_MULT:  r_scale_mult  <= i_cfg_data[MULT_W-1:0];
                CFG_SCALE_SHIFT: r_scale_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output register is full and stalled
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_used = s_axis_tdata[USED_LSB +: USED_W];

    always_comb begin
        n_s1_ctl.valid = s_axis_tvalid;
        n_s1_ctl.last  = s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_en) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // lanes_used above LANES simply turns on every lane
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign w_lane_on[g] = (int'(w_used) > g);

        zdp_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_lane_on(w_lane_on[g]),
            .i_a      (signed'(s_axis_tdata[g*OPND_W +: OPND_W])),
            .i_b      (signed'(s_axis_tdata[(LANES+g)*OPND_W +: OPND_W])),
            .i_zero_a (r_zero_a),
            .i_zero_b (r_zero_b),
            .o_prod   (w_prod[g])
        );
    end

    zdp_merge #(
        .LANES(LANES)
    ) u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (r_s1_ctl),
        .i_prod (w_prod),
        .o_valid(w_sum_valid),
        .o_raw  (w_raw)
    );

    zdp_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_sum_valid),
        .i_raw        (w_raw),
        .i_scale_mult (r_scale_mult),
        .i_scale_shift(r_scale_shift),
        .o_valid      (m_axis_tvalid),
        .o_data       (m_axis_tdata)
    );

endmodule

// ===== src/zdp_lane.sv =====
// ----------------------------------------------------------------------------
// zdp_lane
// One multiply lane: removes both zero points and registers the product.
// A lane that is not in use contributes zero.
// ----------------------------------------------------------------------------
module zdp_lane
    import zdp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_lane_on,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    input  logic signed [OPND_W-1:0] i_zero_a,
    input  logic signed [OPND_W-1:0] i_zero_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [OPND_W:0]   w_da;
    logic signed [OPND_W:0]   w_db;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;

    always_comb begin
        w_da   = (OPND_W+1)'(i_a) - (OPND_W+1)'(i_zero_a);
        w_db   = (OPND_W+1)'(i_b) - (OPND_W+1)'(i_zero_b);
        n_prod = i_lane_on ? PROD_W'(w_da * w_db) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/zdp_merge.sv =====
// ----------------------------------------------------------------------------
// zdp_merge
// Adds the lane products into the running sum. On the last beat of a dot
// product the total is handed on and the running sum clears.
// ----------------------------------------------------------------------------
module zdp_merge
    import zdp_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  t_beat_ctl                       i_ctl,
    input  logic signed [LANES-1:0][PROD_W-1:0] i_prod,
    output logic                            o_valid,
    output logic signed [SUM_W-1:0]         o_raw
);

    logic [SUM_W-1:0]        w_lane_sum;
    logic [SUM_W-1:0]        w_total;
    logic [SUM_W-1:0]        r_acc;
    logic [SUM_W-1:0]        r_raw;
    logic                    r_valid;

    always_comb begin
        w_lane_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            // an element select of the packed array is unsigned
            w_lane_sum = w_lane_sum + SUM_W'(signed'(i_prod[i]));
        end
        w_total = r_acc + w_lane_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid & i_ctl.last;
            if (i_ctl.valid) begin
                r_acc <= i_ctl.last ? '0 : w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid && i_ctl.last) begin
            r_raw <= w_total;
        end
    end

    assign o_valid = r_valid;
    assign o_raw   = signed'(r_raw);

endmodule

// ===== src/zdp_scale.sv =====
// ----------------------------------------------------------------------------
// zdp_scale
// Fixed-point rescale of a finished sum: 32x32 signed multiply, then add
// half an LSB and shift right arithmetically. Ends in the output register.
// ----------------------------------------------------------------------------
module zdp_scale
    import zdp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [SUM_W-1:0]    i_raw,
    input  logic [MULT_W-1:0]          i_scale_mult,
    input  logic [SHIFT_W-1:0]         i_scale_shift,
    output logic                       o_valid,
    output logic [OUT_TDATA_W-1:0]     o_data
);

    logic signed [SUM_W-1:0]      w_mult_s;
    logic signed [SCALED_W-1:0]   w_prod;
    logic signed [SCALED_W-1:0]   w_round;
    logic signed [SCALED_W-1:0]   w_biased;
    logic signed [SCALED_W-1:0]   w_scaled;

    logic signed [SCALED_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]      r_raw_d;
    logic                         r_prod_valid;
    logic [OUT_TDATA_W-1:0]       r_out;
    logic                         r_out_valid;

    always_comb begin
        w_mult_s = signed'({1'b0, i_scale_mult});
        w_prod   = SCALED_W'(i_raw) * SCALED_W'(w_mult_s);
        if (i_scale_shift == '0) begin
            w_round = '0;
        end else begin
            w_round = signed'(SCALED_W'(1) << (i_scale_shift - SHIFT_W'(1)));
        end
        // no overflow: |prod| < 2^62 and the bias is at most 2^62
        w_biased = r_prod + w_round;
        w_scaled = w_biased >>> i_scale_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= w_prod;
            r_raw_d <= i_raw;
            if (r_prod_valid) begin
                r_out <= {w_scaled, r_raw_d};
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== dv/tb_int8_zero_point_dot_product_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_zero_point_dot_product_unit
// Self-checking bench for the INT8 zero-point dot product unit: a scoreboard
// predicts raw and scaled sums per run from accepted beats, tasks drive
// directed and random runs under several register settings with random idling
// on both streams, a stretch without idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_int8_zero_point_dot_product_unit;
    import zdp_pkg::*;

    localparam int LANES      = 4;
    localparam int IN_W       = ((2*LANES*OPND_W+USED_W+7)/8)*8;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [SUM_W-1:0]    raw_sum;
        logic [SCALED_W-1:0] scaled_value;
    } t_dot_result;

    class zp_dot_scoreboard;
        logic [SUM_W-1:0]     running_sum;
        logic signed [7:0]    zero_a;
        logic signed [7:0]    zero_b;
        logic [MULT_W-1:0]    scale_mult;
        logic [SHIFT_W-1:0]   scale_shift;
        t_dot_result          expected_sums[$];
        int                   mismatches;

        function new();
            running_sum = '0;
            zero_a      = '0;
            zero_b      = '0;
            scale_mult  = MULT_W'(1);
            scale_shift = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                CFG_ZERO_A:      zero_a      = data[7:0];
                CFG_ZERO_B:      zero_b      = data[7:0];
                CFG_SCALE_MULT:  scale_mult  = data[MULT_W-1:0];
                CFG_SCALE_SHIFT: scale_shift = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // (sum * mult + half) >>> shift, exact in 64 bits
        function logic [SCALED_W-1:0] scale_sum(logic [SUM_W-1:0] sum);
            longint p;
            p = longint'(signed'(sum)) * longint'(scale_mult);
            if (scale_shift != 0)
                p += longint'(1) << (scale_shift - 1);
            return p >>> scale_shift;
        endfunction

        function void note_beat(logic [IN_W-1:0] beat, logic last);
            int          used;
            int          da;
            int          db;
            t_dot_result res;
            used = int'(beat[2*LANES*OPND_W +: USED_W]);
            if (used > LANES)
                used = LANES;
            for (int i = 0; i < used; i++) begin
                da = $signed(beat[OPND_W*i +: OPND_W]) - zero_a;
                db = $signed(beat[LANES*OPND_W + OPND_W*i +: OPND_W]) - zero_b;
                running_sum += da * db;
            end
            if (last) begin
                res.raw_sum      = running_sum;
                res.scaled_value = scale_sum(running_sum);
                expected_sums.push_back(res);
                running_sum = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] beat);
            t_dot_result exp_res;
            if (expected_sums.size() == 0) begin
                report($sformatf("unexpected result beat %h", beat));
            end else begin
                exp_res = expected_sums.pop_front();
                if (beat[SUM_W-1:0] !== exp_res.raw_sum)
                    report($sformatf("raw_sum got %h want %h",
                                     beat[SUM_W-1:0], exp_res.raw_sum));
                if (beat[SUM_W +: SCALED_W] !== exp_res.scaled_value)
                    report($sformatf("scaled_value got %h want %h",
                                     beat[SUM_W +: SCALED_W], exp_res.scaled_value));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    zp_dot_scoreboard dot_board = new();

    int feed_idle_pct  = 35;
    int drain_idle_pct = 35;
    int drain_hold_cycles = 0;
    int stall_cycles = 0;

    int8_zero_point_dot_product_unit #(
        .LANES(LANES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // random operands, edge values now and then; pad bits stay zero
    function automatic logic [IN_W-1:0] rand_beat(logic [USED_W-1:0] used);
        logic [IN_W-1:0]   b;
        logic [OPND_W-1:0] v;
        b = '0;
        for (int i = 0; i < 2*LANES; i++) begin
            v = OPND_W'($urandom);
            if ($urandom_range(3) == 0)
                v = ($urandom_range(1) != 0) ? 8'h80 : 8'h7f;
            b[OPND_W*i +: OPND_W] = v;
        end
        b[2*LANES*OPND_W +: USED_W] = used;
        return b;
    endfunction

    // tvalid is dropped only by idling or by wait_drain, never at the accept edge
    task automatic send_beat(logic [IN_W-1:0] data, logic last);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic run_random(int n_beats);
        int left;
        left = 0;
        for (int k = 0; k < n_beats; k++) begin
            if (left == 0)
                left = int'($urandom_range(8, 1));
            left--;
            send_beat(rand_beat(USED_W'($urandom_range(7))),
                      (left == 0) || (k == n_beats - 1));
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (dot_board.expected_sums.size() != 0);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        dot_board.set_reg(idx, data);
    endtask

    // upper data bits carry junk that the block must ignore
    task automatic configure(logic [7:0] za, logic [7:0] zb,
                             logic [MULT_W-1:0] mult, logic [SHIFT_W-1:0] shift);
        write_reg(CFG_ZERO_A, {23'($urandom), za});
        write_reg(CFG_ZERO_B, {23'($urandom), zb});
        write_reg(CFG_SCALE_MULT, mult);
        write_reg(CFG_SCALE_SHIFT, {25'($urandom), shift});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random idling, or a counted hold-off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (drain_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                drain_hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= drain_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                dot_board.note_beat(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                dot_board.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("int8_zero_point_dot_product_unit verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, every lanes_used code including zero and over range
        for (int u = 0; u < 8; u++)
            send_beat(rand_beat(USED_W'(u)), 1'b1);
        wait_drain();

        for (int c = 0; c < 6; c++) begin
            configure(8'($urandom), 8'($urandom), MULT_W'($urandom),
                      SHIFT_W'($urandom_range(63)));
            run_random(90);
            wait_drain();
        end

        // extreme zero points, largest multiplier, largest and zero shift
        configure(8'h80, 8'h7f, 31'h7fffffff, 6'd63);
        run_random(40);
        wait_drain();
        configure(8'h7f, 8'h80, 31'h7fffffff, 6'd0);
        run_random(40);
        wait_drain();

        // no idling on either side
        configure(8'($urandom), 8'($urandom), MULT_W'($urandom), 6'd31);
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        run_random(100);
        wait_drain();

        // receiver holds off while the sender keeps offering results
        drain_idle_pct    = 35;
        drain_hold_cycles = 60;
        for (int k = 0; k < 40; k++)
            send_beat(rand_beat(USED_W'($urandom_range(7))), 1'b1);
        wait_drain();
        feed_idle_pct = 35;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dot_board.mismatches == 0 && dot_board.expected_sums.size() == 0)
            $display("int8_zero_point_dot_product_unit verification clean");
        else
            $display("int8_zero_point_dot_product_unit verification failed");
        $finish;
    end

endmodule
